@@ src/dac_nibble_random_access_defines.svh @@
// Assertion macros used by the checker file dnra_checker.sv.
`ifndef DAC_NIBBLE_RANDOM_ACCESS_DEFINES_SVH
`define DAC_NIBBLE_RANDOM_ACCESS_DEFINES_SVH

// Same-cycle implication.
`define DNRA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dnra check failed: same-cycle implication");

// Next-cycle implication.
`define DNRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dnra check failed: next-cycle implication");

`endif

@@ src/dnra_pkg.sv @@
package dnra_pkg;

   localparam int LEVELS_DEF  = 8;
   localparam int ENTRIES_DEF = 65536;

   localparam int LEVEL_W  = 3;
   localparam int CHUNK_W  = 4;
   localparam int INDEX_W  = 16;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int WALKED_W = 4;

   localparam logic FUNC_APPEND = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NOT_LOADED = 2'd1,
      STATUS_LEVEL_FULL = 2'd2,
      STATUS_PAST_LAST  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_READ,
      S_FIN
   } state_type;

   typedef struct packed {
      logic               func;
      logic               level_ok;
      logic [LEVEL_W-1:0] level;
      logic               continue_bit;
      logic [CHUNK_W-1:0] chunk;
      logic [INDEX_W-1:0] index;
   } op_type;

endpackage

@@ src/dnra_front.sv @@
module dnra_front #(
   parameter int LEVELS = dnra_pkg::LEVELS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic [dnra_pkg::LEVEL_W-1:0] req_level,
   input  logic                         req_continue_bit,
   input  logic [dnra_pkg::CHUNK_W-1:0] req_chunk,
   input  logic [dnra_pkg::INDEX_W-1:0] req_index,
   output logic                         q_valid,
   output dnra_pkg::op_type             q_op,
   input  logic                         q_pop
);

   dnra_pkg::op_type slot_ff [2];
   dnra_pkg::op_type op_in;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign req_stall = (count_ff == 2'd2);
   assign q_valid   = (count_ff != 2'd0);
   assign q_op      = slot_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && q_valid;

   always_comb begin
      op_in.func         = req_func;
      op_in.level_ok     = (32'(req_level) < LEVELS);
      op_in.level        = req_level;
      op_in.continue_bit = req_continue_bit;
      op_in.chunk        = req_chunk;
      op_in.index        = req_index;
   end

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= op_in;
      end
   end

endmodule

@@ src/dnra_back.sv @@
module dnra_back #(
   parameter int LEVELS            = dnra_pkg::LEVELS_DEF,
   parameter int ENTRIES_PER_LEVEL = dnra_pkg::ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  dnra_pkg::op_type              q_op,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dnra_pkg::VALUE_W-1:0]  rsp_value,
   output logic [dnra_pkg::STATUS_W-1:0] rsp_status,
   output logic [dnra_pkg::WALKED_W-1:0] rsp_levels_walked
);

   localparam int AW    = $clog2(ENTRIES_PER_LEVEL);
   localparam int FW    = $clog2(ENTRIES_PER_LEVEL + 1);
   localparam int PW    = (AW > dnra_pkg::INDEX_W) ? AW : dnra_pkg::INDEX_W;
   localparam int CW    = (PW > FW) ? PW : FW;
   localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int WW    = LW + 1;
   localparam int DEPTH = LEVELS * ENTRIES_PER_LEVEL;
   localparam int MAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int MW    = 1 + dnra_pkg::CHUNK_W + AW;
   localparam int VW    = dnra_pkg::VALUE_W;

   dnra_pkg::state_type state_ff, state_in;

   logic [MW-1:0] mem [DEPTH];
   logic [MW-1:0] rd_data_ff;

   logic [FW-1:0] fill_ff [LEVELS];
   logic [FW-1:0] fill_in [LEVELS];
   logic [FW-1:0] ones_ff [LEVELS];
   logic [FW-1:0] ones_in [LEVELS];

   logic [PW-1:0] pos_ff, pos_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [VW-1:0] acc_ff, acc_in;

   logic [VW-1:0]                 res_value_ff, res_value_in;
   dnra_pkg::status_type          res_status_ff, res_status_in;
   logic [dnra_pkg::WALKED_W-1:0] res_walked_ff, res_walked_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]                 rsp_value_ff, rsp_value_in;
   dnra_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [dnra_pkg::WALKED_W-1:0] rsp_walked_ff, rsp_walked_in;

   logic                      out_free, out_load;
   logic                      is_query, is_append;
   logic [LW-1:0]             op_lvl, rd_lvl;
   logic [FW-1:0]             fill_sel, ones_sel;
   logic                      append_ok, append_do;
   logic                      miss, last;
   logic                      mem_wr, mem_rd;
   logic [MAW-1:0]            wr_addr, rd_addr;
   logic [MW-1:0]             wr_data;
   logic                      rd_cont;
   logic [dnra_pkg::CHUNK_W-1:0] rd_chunk;
   logic [AW-1:0]             rd_rank;
   logic [VW-1:0]             shifted;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_query  = q_valid && (q_op.func == dnra_pkg::FUNC_QUERY);
   assign is_append = q_valid && (q_op.func == dnra_pkg::FUNC_APPEND);
   assign op_lvl    = LW'(q_op.level);
   assign rd_lvl    = (state_ff == dnra_pkg::S_IDLE) ? op_lvl : lvl_ff;
   assign fill_sel  = fill_ff[rd_lvl];
   assign ones_sel  = ones_ff[rd_lvl];
   assign append_ok = q_op.level_ok && (fill_sel != FW'(ENTRIES_PER_LEVEL));
   assign miss      = (CW'(pos_ff) >= CW'(fill_sel));
   assign last      = (lvl_ff == LW'(LEVELS - 1));

   assign wr_addr = MAW'(MAW'(op_lvl) * MAW'(ENTRIES_PER_LEVEL)) + MAW'(fill_sel[AW-1:0]);
   assign rd_addr = MAW'(MAW'(lvl_ff) * MAW'(ENTRIES_PER_LEVEL)) + MAW'(pos_ff[AW-1:0]);
   assign wr_data = {q_op.continue_bit, q_op.chunk, ones_sel[AW-1:0]};

   assign rd_cont  = rd_data_ff[MW-1];
   assign rd_chunk = rd_data_ff[MW-2 -: dnra_pkg::CHUNK_W];
   assign rd_rank  = rd_data_ff[AW-1:0];
   assign shifted  = VW'(rd_chunk) << {lvl_ff, 2'b00};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dnra_pkg::S_IDLE: begin
            if (is_query) begin
               state_in = dnra_pkg::S_CHECK;
            end
         end
         dnra_pkg::S_CHECK: begin
            state_in = miss ? dnra_pkg::S_FIN : dnra_pkg::S_READ;
         end
         dnra_pkg::S_READ: begin
            state_in = (!rd_cont || last) ? dnra_pkg::S_FIN : dnra_pkg::S_CHECK;
         end
         dnra_pkg::S_FIN: begin
            if (out_free) begin
               state_in = dnra_pkg::S_IDLE;
            end
         end
         default: state_in = dnra_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      q_pop         = 1'b0;
      append_do     = 1'b0;
      mem_wr        = 1'b0;
      mem_rd        = 1'b0;
      out_load      = 1'b0;
      pos_in        = pos_ff;
      lvl_in        = lvl_ff;
      acc_in        = acc_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      res_walked_in = res_walked_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_walked_in = rsp_walked_ff;
      fill_in       = fill_ff;
      ones_in       = ones_ff;
      unique case (state_ff)
         dnra_pkg::S_IDLE: begin
            if (is_query) begin
               q_pop  = 1'b1;
               pos_in = PW'(q_op.index);
               lvl_in = '0;
               acc_in = '0;
            end else if (is_append && out_free) begin
               q_pop         = 1'b1;
               out_load      = 1'b1;
               append_do     = append_ok;
               mem_wr        = append_ok;
               rsp_value_in  = '0;
               rsp_walked_in = '0;
               rsp_status_in = append_ok ? dnra_pkg::STATUS_OK
                                         : dnra_pkg::STATUS_LEVEL_FULL;
            end
            if (append_do) begin
               fill_in[op_lvl] = fill_sel + FW'(1);
               ones_in[op_lvl] = ones_sel + FW'(q_op.continue_bit);
            end
         end
         dnra_pkg::S_CHECK: begin
            if (miss) begin
               res_value_in  = '0;
               res_status_in = dnra_pkg::STATUS_NOT_LOADED;
               res_walked_in = dnra_pkg::WALKED_W'(lvl_ff);
            end else begin
               mem_rd = 1'b1;
            end
         end
         dnra_pkg::S_READ: begin
            acc_in = acc_ff + shifted;
            if (!rd_cont) begin
               res_value_in  = acc_in;
               res_status_in = dnra_pkg::STATUS_OK;
               res_walked_in = dnra_pkg::WALKED_W'(WW'(lvl_ff) + WW'(1));
            end else if (last) begin
               res_value_in  = '0;
               res_status_in = dnra_pkg::STATUS_PAST_LAST;
               res_walked_in = dnra_pkg::WALKED_W'(LEVELS);
            end else begin
               pos_in = PW'(rd_rank);
               lvl_in = lvl_ff + LW'(1);
            end
         end
         dnra_pkg::S_FIN: begin
            if (out_free) begin
               out_load      = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
               rsp_walked_in = res_walked_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dnra_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LEVELS; i++) begin
            fill_ff[i] <= '0;
            ones_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
         ones_ff      <= ones_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      lvl_ff        <= lvl_in;
      acc_ff        <= acc_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      res_walked_ff <= res_walked_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_walked_ff <= rsp_walked_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_rd) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value         = rsp_value_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_levels_walked = rsp_walked_ff;

endmodule

@@ src/dac_nibble_random_access.sv @@
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  func, level, continue_bit, chunk, index
// rsp_      out        rsp_valid / rsp_stall  value, status, levels_walked
//
// Append: handled in the back end's idle state, at most one write to the entry memory.
// Query: each level read is a fill check plus one registered read of the
// entry memory, and the next level's address is the rank read; a walk that
// reaches an index that is not loaded ends at the fill check.
// Reset is synchronous; it clears the queue, fill and ones counters and the
// response valid flag; the entry memory is not cleared.
// A stalled result holds in its register while the two-entry queue takes requests until full.
module dac_nibble_random_access #(
   parameter int LEVELS            = dnra_pkg::LEVELS_DEF,
   parameter int ENTRIES_PER_LEVEL = dnra_pkg::ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [dnra_pkg::LEVEL_W-1:0]  req_level,
   input  logic                          req_continue_bit,
   input  logic [dnra_pkg::CHUNK_W-1:0]  req_chunk,
   input  logic [dnra_pkg::INDEX_W-1:0]  req_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dnra_pkg::VALUE_W-1:0]  rsp_value,
   output logic [dnra_pkg::STATUS_W-1:0] rsp_status,
   output logic [dnra_pkg::WALKED_W-1:0] rsp_levels_walked
);

   logic             q_valid;
   logic             q_pop;
   dnra_pkg::op_type q_op;

   dnra_front #(
      .LEVELS (LEVELS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_level        (req_level),
      .req_continue_bit (req_continue_bit),
      .req_chunk        (req_chunk),
      .req_index        (req_index),
      .q_valid          (q_valid),
      .q_op             (q_op),
      .q_pop            (q_pop)
   );

   dnra_back #(
      .LEVELS            (LEVELS),
      .ENTRIES_PER_LEVEL (ENTRIES_PER_LEVEL)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_op              (q_op),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_value         (rsp_value),
      .rsp_status        (rsp_status),
      .rsp_levels_walked (rsp_levels_walked)
   );

endmodule

@@ src/dnra_checker.sv @@
`include "dac_nibble_random_access_defines.svh"

module dnra_checker #(
   parameter int LEVELS = dnra_pkg::LEVELS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [dnra_pkg::VALUE_W-1:0]  rsp_value,
   input logic [dnra_pkg::STATUS_W-1:0] rsp_status,
   input logic [dnra_pkg::WALKED_W-1:0] rsp_levels_walked
);

   `DNRA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_value) && $stable(rsp_status) && $stable(rsp_levels_walked))

   `DNRA_ASSERT_IMPLY(a_err_zero, clock, reset,
      rsp_valid && (rsp_status == dnra_pkg::STATUS_NOT_LOADED ||
                    rsp_status == dnra_pkg::STATUS_PAST_LAST), rsp_value == '0)

   `DNRA_ASSERT_IMPLY(a_past_walk, clock, reset,
      rsp_valid && rsp_status == dnra_pkg::STATUS_PAST_LAST,
      rsp_levels_walked == dnra_pkg::WALKED_W'(LEVELS))

   `DNRA_ASSERT_IMPLY(a_full_walk, clock, reset,
      rsp_valid && rsp_status == dnra_pkg::STATUS_LEVEL_FULL,
      rsp_levels_walked == '0 && rsp_value == '0)

endmodule

bind dac_nibble_random_access dnra_checker #(
   .LEVELS (LEVELS)
) u_dnra_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_value         (rsp_value),
   .rsp_status        (rsp_status),
   .rsp_levels_walked (rsp_levels_walked)
);
